[hdl/coap_hdr_pkg.sv]
// Shared types and constants for the CoAP message header parser.
`timescale 1ns / 1ps

package coap_hdr_pkg;

  localparam int TOKEN_CAP = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;

  typedef enum logic [2:0] {
    EV_HEADER   = 3'd0,
    EV_OPTION   = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_END      = 3'd3,
    EV_BADHDR   = 3'd4,
    EV_TRUNC    = 3'd5,
    EV_OVERSIZE = 3'd6
  } event_kind_t;

  typedef enum logic [1:0] {
    REG_EXPECTED_VERSION = 2'd0,
    REG_TOKEN_LIMIT      = 2'd1,
    REG_OPTION_LIMIT     = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0] expected_version;
    logic [3:0] token_limit;
    logic [4:0] option_limit;
  } cfg_t;

  typedef struct packed {
    event_kind_t kind;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [63:0] token_bytes;
    logic [7:0]  code_byte;
    logic [15:0] message_id;
    logic        is_request;
    logic [7:0]  option_number;
    logic [3:0]  option_length;
    logic [9:0]  value_offset;
    logic        ends_message;
  } event_t;

endpackage

[hdl/coap_hdr_front.sv]
// Byte-level parse engine: header, token and option walk, one event per byte at most.
`timescale 1ns / 1ps

module coap_hdr_front import coap_hdr_pkg::*; #(
  parameter int MAX_DATAGRAM = 1024,
  parameter int MAX_OPTIONS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic       ev_valid,
  output event_t     ev
);

  localparam int PosW = $clog2(MAX_DATAGRAM + 1);
  localparam int OptW = $clog2(MAX_OPTIONS + 1);
  localparam int SumW = (PosW >= 10) ? PosW + 1 : 11;

  typedef enum logic [3:0] {
    PH_H0, PH_H1, PH_H2, PH_H3, PH_TOKEN, PH_OPTHDR, PH_OPTVAL, PH_PAYLOAD, PH_DRAIN
  } phase_t;

  phase_t          phase, phase_next;
  logic [PosW-1:0] pos;
  logic [7:0]      hdr_first, hdr_first_next;
  logic [7:0]      hdr_code, hdr_code_next;
  logic [15:0]     hdr_msgid, hdr_msgid_next;
  logic [63:0]     token_store, token_store_next;
  logic [3:0]      bytes_left, bytes_left_next;
  logic [OptW-1:0] options_seen, options_seen_next;
  logic [7:0]      last_num, last_num_next;

  logic [SumW-1:0] pos_wide, pos_inc;
  logic [3:0]      tok_lim;
  logic [4:0]      opt_lim;
  logic [7:0]      num;
  logic [3:0]      len;
  event_kind_t     kind;
  logic [7:0]      ev_onum;
  logic [3:0]      ev_olen;
  logic [9:0]      ev_off;
  logic            ev_ends;

  always_comb begin
    pos_wide = SumW'(pos);
    pos_inc = pos_wide + SumW'(1);
    tok_lim = (cfg.token_limit > 4'(TOKEN_CAP)) ? 4'(TOKEN_CAP) : cfg.token_limit;
    opt_lim = (cfg.option_limit > 5'(MAX_OPTIONS)) ? 5'(MAX_OPTIONS) : cfg.option_limit;
    num = last_num + {4'd0, data_byte[7:4]};
    len = data_byte[3:0];

    phase_next = phase;
    hdr_first_next = hdr_first;
    hdr_code_next = hdr_code;
    hdr_msgid_next = hdr_msgid;
    token_store_next = token_store;
    bytes_left_next = bytes_left;
    options_seen_next = options_seen;
    last_num_next = last_num;
    ev_valid = 1'b0;
    kind = EV_HEADER;
    ev_onum = 8'd0;
    ev_olen = 4'd0;
    ev_off = 10'd0;
    ev_ends = last_byte;

    if (phase != PH_DRAIN && pos >= PosW'(MAX_DATAGRAM)) begin
      ev_valid = 1'b1;
      kind = EV_OVERSIZE;
      phase_next = PH_DRAIN;
    end else begin
      unique case (phase)
        PH_H0: begin
          hdr_first_next = data_byte;
          phase_next = PH_H1;
          if (last_byte) begin
            ev_valid = 1'b1;
            kind = EV_TRUNC;
          end
        end
        PH_H1: begin
          hdr_code_next = data_byte;
          phase_next = PH_H2;
          if (last_byte) begin
            ev_valid = 1'b1;
            kind = EV_TRUNC;
          end
        end
        PH_H2: begin
          hdr_msgid_next = {data_byte, 8'd0};
          phase_next = PH_H3;
          if (last_byte) begin
            ev_valid = 1'b1;
            kind = EV_TRUNC;
          end
        end
        PH_H3: begin
          hdr_msgid_next = {hdr_msgid[15:8], data_byte};
          if (hdr_first[7:6] != cfg.expected_version || hdr_first[3:0] > tok_lim) begin
            ev_valid = 1'b1;
            kind = EV_BADHDR;
            phase_next = PH_DRAIN;
          end else if (hdr_first[3:0] == 4'd0) begin
            ev_valid = 1'b1;
            kind = EV_HEADER;
            phase_next = PH_OPTHDR;
          end else if (last_byte) begin
            ev_valid = 1'b1;
            kind = EV_TRUNC;
          end else begin
            bytes_left_next = hdr_first[3:0];
            phase_next = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          token_store_next = {token_store[55:0], data_byte};
          bytes_left_next = bytes_left - 4'd1;
          if (bytes_left_next == 4'd0) begin
            ev_valid = 1'b1;
            kind = EV_HEADER;
            phase_next = PH_OPTHDR;
          end else if (last_byte) begin
            ev_valid = 1'b1;
            kind = EV_TRUNC;
          end
        end
        PH_OPTHDR: begin
          ev_valid = 1'b1;
          if (5'(options_seen) >= opt_lim) begin
            kind = EV_PAYLOAD;
            ev_off = pos_wide[9:0];
            phase_next = PH_PAYLOAD;
          end else if (data_byte == PAYLOAD_MARKER) begin
            kind = EV_PAYLOAD;
            ev_off = pos_inc[9:0];
            phase_next = PH_PAYLOAD;
          end else begin
            last_num_next = num;
            options_seen_next = options_seen + OptW'(1);
            if (last_byte && len != 4'd0) begin
              kind = EV_TRUNC;
            end else begin
              kind = EV_OPTION;
              ev_onum = num;
              ev_olen = len;
              ev_off = pos_inc[9:0];
              if (len != 4'd0) begin
                bytes_left_next = len;
                phase_next = PH_OPTVAL;
              end
            end
          end
        end
        PH_OPTVAL: begin
          bytes_left_next = bytes_left - 4'd1;
          if (bytes_left_next == 4'd0) begin
            phase_next = PH_OPTHDR;
            if (last_byte) begin
              ev_valid = 1'b1;
              kind = EV_END;
              ev_off = pos_wide[9:0];
            end
          end else if (last_byte) begin
            ev_valid = 1'b1;
            kind = EV_TRUNC;
          end
        end
        PH_PAYLOAD: begin
          if (last_byte) begin
            ev_valid = 1'b1;
            kind = EV_END;
            ev_off = pos_wide[9:0];
          end
        end
        PH_DRAIN: begin
        end
        default: begin
          phase_next = PH_DRAIN;
        end
      endcase
    end

    ev.kind = kind;
    ev.msg_type = hdr_first_next[5:4];
    ev.token_len = hdr_first_next[3:0];
    ev.token_bytes = token_store_next;
    ev.code_byte = hdr_code_next;
    ev.message_id = hdr_msgid_next;
    ev.is_request = (hdr_code_next >= 8'd1) && (hdr_code_next <= 8'd4);
    ev.option_number = ev_onum;
    ev.option_length = ev_olen;
    ev.value_offset = ev_off;
    ev.ends_message = ev_ends;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase <= PH_H0;
      pos <= '0;
      hdr_first <= 8'd0;
      hdr_code <= 8'd0;
      hdr_msgid <= 16'd0;
      token_store <= 64'd0;
      bytes_left <= 4'd0;
      options_seen <= '0;
      last_num <= 8'd0;
    end else if (take) begin
      phase <= phase_next;
      if (pos < PosW'(MAX_DATAGRAM)) begin
        pos <= pos + PosW'(1);
      end
      hdr_first <= hdr_first_next;
      hdr_code <= hdr_code_next;
      hdr_msgid <= hdr_msgid_next;
      token_store <= token_store_next;
      bytes_left <= bytes_left_next;
      options_seen <= options_seen_next;
      last_num <= last_num_next;
    end
  end

endmodule

[hdl/coap_hdr_queue.sv]
// Short event queue between the parse engine and the result port.
`timescale 1ns / 1ps

module coap_hdr_queue import coap_hdr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  event_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output logic   empty,
  output event_t rd_data
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  event_t          entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign full = (count == CntW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[hdl/coap_message_header_parser_unit.sv]
// CoAP message header parser: top level with configuration registers.
//
// Usage: datagram bytes enter through push/full, one byte per cycle while
// full is low, with last_byte marking the final byte. Each byte gives at
// most one event (header, option, payload start, end, bad header,
// truncated, oversize), which is queued and shown on the result ports
// while empty is low; pop takes the oldest one.
// Throughput: one byte per cycle while the result side keeps up.
// Each event is queued as its byte is taken, behind any older events.
// A four-entry event queue parts the parse engine from the result port;
// when the receiver stalls, full rises once four events wait and input
// stops until pop frees an entry. Bytes that give no event never fill it.
// Configuration: cfg_valid/cfg_ready write one register per request
// (index 0 expected version, 1 token limit, 2 option limit); cfg_ready is
// always high. Write only while no datagram is in progress.
// Reset: rst clears the parse state and the queue and loads the register
// defaults (version 1, token limit 8, option limit 16).
`timescale 1ns / 1ps

module coap_message_header_parser_unit import coap_hdr_pkg::*; #(
  parameter int MAX_DATAGRAM = 1024,
  parameter int MAX_OPTIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_kind,
  output logic [1:0]  msg_type,
  output logic [3:0]  token_len,
  output logic [63:0] token_bytes,
  output logic [7:0]  code_byte,
  output logic [15:0] message_id,
  output logic        is_request,
  output logic [7:0]  option_number,
  output logic [3:0]  option_length,
  output logic [9:0]  value_offset,
  output logic        ends_message,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  cfg_t   cfg;
  logic   take;
  logic   ev_valid;
  event_t ev;
  event_t head;

  assign cfg_ready = 1'b1;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= 2'd1;
      cfg.token_limit <= 4'd8;
      cfg.option_limit <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXPECTED_VERSION: cfg.expected_version <= cfg_data[1:0];
        REG_TOKEN_LIMIT:      cfg.token_limit <= cfg_data[3:0];
        REG_OPTION_LIMIT:     cfg.option_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  coap_hdr_front #(
    .MAX_DATAGRAM(MAX_DATAGRAM),
    .MAX_OPTIONS(MAX_OPTIONS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .cfg(cfg),
    .ev_valid(ev_valid),
    .ev(ev)
  );

  coap_hdr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(take && ev_valid),
    .wr_data(ev),
    .full(full),
    .rd_en(pop),
    .empty(empty),
    .rd_data(head)
  );

  assign event_kind = head.kind;
  assign msg_type = head.msg_type;
  assign token_len = head.token_len;
  assign token_bytes = head.token_bytes;
  assign code_byte = head.code_byte;
  assign message_id = head.message_id;
  assign is_request = head.is_request;
  assign option_number = head.option_number;
  assign option_length = head.option_length;
  assign value_offset = head.value_offset;
  assign ends_message = head.ends_message;

endmodule

[verif/tb_coap_message_header_parser_unit.sv]
// CoAP header parser testbench: directed and random datagrams checked by a scoreboard.
`timescale 1ns / 1ps

import coap_hdr_pkg::*;

typedef enum logic [3:0] {
  ST_HDR0, ST_HDR1, ST_HDR2, ST_HDR3, ST_TOKEN, ST_OPT_HDR, ST_OPT_VAL, ST_PAYLOAD, ST_DRAIN
} parse_step_t;

class coap_parse_scoreboard;
  localparam int MAX_DATAGRAM = 1024;
  localparam int MAX_OPTIONS = 16;

  bit [1:0] exp_ver;
  bit [3:0] tok_lim;
  bit [4:0] opt_lim;

  parse_step_t step;
  bit [10:0] pos;
  bit [7:0] first_byte;
  bit [7:0] code;
  bit [15:0] msg_id;
  bit [63:0] token;
  bit [3:0] bytes_left;
  bit [4:0] n_opts;
  bit [7:0] opt_num;

  event_t expected_events[$];
  int errors;
  int parsed_bytes;

  function new();
    exp_ver = 2'd1;
    tok_lim = 4'd8;
    opt_lim = 5'd16;
    errors = 0;
    parsed_bytes = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    step = ST_HDR0;
    pos = '0;
    first_byte = '0;
    code = '0;
    msg_id = '0;
    token = '0;
    bytes_left = '0;
    n_opts = '0;
    opt_num = '0;
  endfunction

  function void set_reg(reg_index_t idx, bit [4:0] val);
    case (idx)
      REG_EXPECTED_VERSION: exp_ver = val[1:0];
      REG_TOKEN_LIMIT:      tok_lim = val[3:0];
      REG_OPTION_LIMIT:     opt_lim = val;
      default: ;
    endcase
  endfunction

  function void queue_event(event_kind_t kind, bit [7:0] onum, bit [3:0] olen, int off,
                            bit ends);
    event_t ev;
    ev.kind = kind;
    ev.msg_type = first_byte[5:4];
    ev.token_len = first_byte[3:0];
    ev.token_bytes = token;
    ev.code_byte = code;
    ev.message_id = msg_id;
    ev.is_request = (code >= 8'd1 && code <= 8'd4);
    ev.option_number = onum;
    ev.option_length = olen;
    ev.value_offset = off[9:0];
    ev.ends_message = ends;
    expected_events.push_back(ev);
  endfunction

  // Accepted request: advance the parse state and queue any event it causes.
  function void note_byte(bit [7:0] b, bit lst);
    int lim;
    int here;
    bit [7:0] num;
    bit [3:0] len;
    here = pos;
    if (step != ST_DRAIN) parsed_bytes++;
    if (step != ST_DRAIN && here >= MAX_DATAGRAM) begin
      queue_event(EV_OVERSIZE, 0, 0, 0, lst);
      step = ST_DRAIN;
    end else begin
      case (step)
        ST_HDR0: begin
          first_byte = b;
          step = ST_HDR1;
          if (lst) queue_event(EV_TRUNC, 0, 0, 0, 1'b1);
        end
        ST_HDR1: begin
          code = b;
          step = ST_HDR2;
          if (lst) queue_event(EV_TRUNC, 0, 0, 0, 1'b1);
        end
        ST_HDR2: begin
          msg_id = {b, 8'h00};
          step = ST_HDR3;
          if (lst) queue_event(EV_TRUNC, 0, 0, 0, 1'b1);
        end
        ST_HDR3: begin
          lim = (tok_lim > TOKEN_CAP) ? TOKEN_CAP : tok_lim;
          msg_id[7:0] = b;
          if (first_byte[7:6] != exp_ver || first_byte[3:0] > lim) begin
            queue_event(EV_BADHDR, 0, 0, 0, lst);
            step = ST_DRAIN;
          end else if (first_byte[3:0] == 4'd0) begin
            queue_event(EV_HEADER, 0, 0, 0, lst);
            step = ST_OPT_HDR;
          end else if (lst) begin
            queue_event(EV_TRUNC, 0, 0, 0, 1'b1);
          end else begin
            bytes_left = first_byte[3:0];
            step = ST_TOKEN;
          end
        end
        ST_TOKEN: begin
          token = {token[55:0], b};
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == 4'd0) begin
            queue_event(EV_HEADER, 0, 0, 0, lst);
            step = ST_OPT_HDR;
          end else if (lst) begin
            queue_event(EV_TRUNC, 0, 0, 0, 1'b1);
          end
        end
        ST_OPT_HDR: begin
          lim = (opt_lim > MAX_OPTIONS) ? MAX_OPTIONS : opt_lim;
          if (n_opts >= lim) begin
            // limit reached: this byte is payload even if it is the marker
            queue_event(EV_PAYLOAD, 0, 0, here, lst);
            step = ST_PAYLOAD;
          end else if (b == PAYLOAD_MARKER) begin
            queue_event(EV_PAYLOAD, 0, 0, here + 1, lst);
            step = ST_PAYLOAD;
          end else begin
            num = opt_num + 8'(b[7:4]);
            len = b[3:0];
            opt_num = num;
            n_opts = n_opts + 5'd1;
            if (lst && len != 4'd0) begin
              queue_event(EV_TRUNC, 0, 0, 0, 1'b1);
            end else begin
              queue_event(EV_OPTION, num, len, here + 1, lst);
              if (len != 4'd0) begin
                bytes_left = len;
                step = ST_OPT_VAL;
              end
            end
          end
        end
        ST_OPT_VAL: begin
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == 4'd0) begin
            step = ST_OPT_HDR;
            if (lst) queue_event(EV_END, 0, 0, here, 1'b1);
          end else if (lst) begin
            queue_event(EV_TRUNC, 0, 0, 0, 1'b1);
          end
        end
        ST_PAYLOAD: begin
          if (lst) queue_event(EV_END, 0, 0, here, 1'b1);
        end
        default: ;
      endcase
    end
    if (lst) clear_frame();
    else if (pos < MAX_DATAGRAM) pos = pos + 11'd1;
  endfunction

  function void cmp(string name, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, seen);
      errors++;
    end
  endfunction

  function void check_result(event_t got);
    event_t want;
    if (expected_events.size() == 0) begin
      $error("event_kind: expected none, actual %0d", got.kind);
      errors++;
      return;
    end
    want = expected_events.pop_front();
    cmp("event_kind", 64'(want.kind), 64'(got.kind));
    cmp("msg_type", 64'(want.msg_type), 64'(got.msg_type));
    cmp("token_len", 64'(want.token_len), 64'(got.token_len));
    cmp("token_bytes", want.token_bytes, got.token_bytes);
    cmp("code_byte", 64'(want.code_byte), 64'(got.code_byte));
    cmp("message_id", 64'(want.message_id), 64'(got.message_id));
    cmp("is_request", 64'(want.is_request), 64'(got.is_request));
    cmp("option_number", 64'(want.option_number), 64'(got.option_number));
    cmp("option_length", 64'(want.option_length), 64'(got.option_length));
    cmp("value_offset", 64'(want.value_offset), 64'(got.value_offset));
    cmp("ends_message", 64'(want.ends_message), 64'(got.ends_message));
  endfunction
endclass

module tb_coap_message_header_parser_unit;

  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte = 8'h00;
  logic last_byte = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] event_kind;
  logic [1:0] msg_type;
  logic [3:0] token_len;
  logic [63:0] token_bytes;
  logic [7:0] code_byte;
  logic [15:0] message_id;
  logic is_request;
  logic [7:0] option_number;
  logic [3:0] option_length;
  logic [9:0] value_offset;
  logic ends_message;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_index_t cfg_index = REG_EXPECTED_VERSION;
  logic [4:0] cfg_data = 5'd0;

  coap_parse_scoreboard sb = new();
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit [7:0] frame[$];
  event_t got;

  coap_message_header_parser_unit u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop),
    .event_kind(event_kind), .msg_type(msg_type), .token_len(token_len),
    .token_bytes(token_bytes), .code_byte(code_byte), .message_id(message_id),
    .is_request(is_request), .option_number(option_number),
    .option_length(option_length), .value_offset(value_offset),
    .ends_message(ends_message),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        got.kind = event_kind_t'(event_kind);
        got.msg_type = msg_type;
        got.token_len = token_len;
        got.token_bytes = token_bytes;
        got.code_byte = code_byte;
        got.message_id = message_id;
        got.is_request = is_request;
        got.option_number = option_number;
        got.option_length = option_length;
        got.value_offset = value_offset;
        got.ends_message = ends_message;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_byte(bit [7:0] b, bit lst);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (full);
    sb.note_byte(b, lst);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic send_list(bit [7:0] bytes[$]);
    frame = bytes;
    send_frame();
  endtask

  // Parser is idle once every event is in and the last byte had time to settle.
  task automatic settle();
    push <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_index_t idx, bit [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(bit [4:0] ver, bit [4:0] tok, bit [4:0] opt);
    cfg_write(REG_EXPECTED_VERSION, ver);
    cfg_write(REG_TOKEN_LIMIT, tok);
    cfg_write(REG_OPTION_LIMIT, opt);
    cfg_valid <= 1'b0;
  endtask

  task automatic make_frame();
    int tkl;
    int lim;
    int olen;
    int tail;
    int cut;
    bit [1:0] ver;
    frame.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom));
      return;
    end
    lim = (sb.tok_lim > TOKEN_CAP) ? TOKEN_CAP : sb.tok_lim;
    ver = ($urandom_range(0, 11) == 0) ? 2'($urandom) : sb.exp_ver;
    tkl = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : $urandom_range(0, lim);
    frame.push_back({ver, 2'($urandom), 4'(tkl)});
    frame.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom));
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    repeat (tkl) frame.push_back(8'($urandom));
    repeat ($urandom_range(0, 18)) begin
      olen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      frame.push_back({4'($urandom), 4'(olen)});
      repeat (olen) frame.push_back(8'($urandom));
    end
    tail = $urandom_range(0, 2);
    if (tail != 0) begin
      frame.push_back(PAYLOAD_MARKER);
      if (tail == 2) repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, frame.size());
      while (frame.size() > cut) void'(frame.pop_back());
    end
  endtask

  initial begin
    int goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header, token, option with delta 13, marker, payload end
    send_list('{8'h41, 8'h02, 8'hAB, 8'hCD, 8'h7E, 8'hD1, 8'h80, 8'hFF, 8'h00});
    // token length above the limit
    send_list('{8'h4F, 8'hFF, 8'hFF, 8'hFF});
    // final byte inside the header
    send_list('{8'h40});
    // marker as final byte
    send_list('{8'h40, 8'h45, 8'h00, 8'h01, 8'hFF});
    // final option header with no value
    send_list('{8'h70, 8'hFF, 8'hFF, 8'hFF, 8'hF0});

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: configure(5'd0, 5'd0, 5'd0);
        1: configure(5'd3, 5'd15, 5'd31);
        2: configure(5'd1, 5'd8, 5'd16);
        3: configure(5'd2, 5'd1, 5'd1);
        default: configure(5'($urandom), 5'($urandom), 5'($urandom));
      endcase
      if (ph == 7) idle_on = 1'b0;
      goal = sb.parsed_bytes + 80;
      while (sb.parsed_bytes < goal) begin
        if (ph != 7) idle_on = ($urandom_range(0, 3) != 0);
        make_frame();
        send_frame();
      end
    end

    push <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
